[src/iht_pkg.sv]
// shared types, codes and constants for the heading tracker
// no dependencies
`default_nettype none

package iht_pkg;

  localparam int HISTORY_DEPTH_DEF = 8;
  localparam int CORDIC_STEPS      = 20;
  localparam int XY_W              = 45;
  localparam int Z_W               = 27;
  localparam int ANG_W             = 16;
  localparam int HALF_TURN         = 11520;
  localparam int FULL_TURN         = 23040;
  localparam int NORM_SHIFT        = 40;

  localparam logic [2:0] KIND_ROT     = 3'd0;
  localparam logic [2:0] KIND_GEO_ROT = 3'd1;
  localparam logic [2:0] KIND_RAW_MAG = 3'd2;
  localparam logic [2:0] KIND_ACCEL   = 3'd3;
  localparam logic [2:0] KIND_GYRO    = 3'd4;
  localparam logic [2:0] KIND_CAL_MAG = 3'd5;

  localparam logic [1:0] MODE_MAG = 2'd0;
  localparam logic [1:0] MODE_YAW = 2'd1;

  localparam logic [2:0] REG_HEADING_MODE = 3'd0;
  localparam logic [2:0] REG_YAW_OFFSET   = 3'd1;
  localparam logic [2:0] REG_MAG_X_MIN    = 3'd2;
  localparam logic [2:0] REG_MAG_X_MAX    = 3'd3;
  localparam logic [2:0] REG_MAG_Y_MIN    = 3'd4;
  localparam logic [2:0] REG_MAG_Y_MAX    = 3'd5;

  localparam logic [1:0] ACC_HIGH = 2'd3;

  typedef enum logic [4:0] {
    DP_NOP    = 5'd0,
    DP_LATCH  = 5'd1,
    DP_STORE  = 5'd2,
    DP_MUL1   = 5'd3,
    DP_MUL2   = 5'd4,
    DP_LDYAW  = 5'd5,
    DP_LDMAG  = 5'd6,
    DP_AINIT  = 5'd7,
    DP_NORM   = 5'd8,
    DP_CORDIC = 5'd9,
    DP_ROUND  = 5'd10,
    DP_LDH    = 5'd11,
    DP_PUSH   = 5'd12,
    DP_RD     = 5'd13,
    DP_ACC    = 5'd14,
    DP_DIVINIT = 5'd15,
    DP_DIV    = 5'd16,
    DP_OUTLD  = 5'd17
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } iht_cmd_t;

  typedef struct packed {
    logic       cmd;
    logic [2:0] kind;
    logic [1:0] mode;
    logic       xy_zero;
    logic       norm_done;
    logic       cordic_last;
    logic       sweep_last;
    logic       div_last;
    logic       out_free;
  } iht_status_t;

  function automatic logic signed [22:0] atan_lut(input logic [4:0] s);
    logic signed [22:0] v;
    unique case (s)
      5'd0:  v = 23'sd2949120;
      5'd1:  v = 23'sd1740967;
      5'd2:  v = 23'sd919879;
      5'd3:  v = 23'sd466945;
      5'd4:  v = 23'sd234379;
      5'd5:  v = 23'sd117304;
      5'd6:  v = 23'sd58666;
      5'd7:  v = 23'sd29335;
      5'd8:  v = 23'sd14668;
      5'd9:  v = 23'sd7334;
      5'd10: v = 23'sd3667;
      5'd11: v = 23'sd1833;
      5'd12: v = 23'sd917;
      5'd13: v = 23'sd458;
      5'd14: v = 23'sd229;
      5'd15: v = 23'sd115;
      5'd16: v = 23'sd57;
      5'd17: v = 23'sd29;
      5'd18: v = 23'sd14;
      5'd19: v = 23'sd7;
      default: v = 23'sd0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

[src/iht_ctrl.sv]
// sequencing state machine for the heading tracker
// depends on iht_pkg
`default_nettype none

module iht_ctrl (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  output logic                in_stall,
  input  iht_pkg::iht_status_t st,
  output iht_pkg::iht_cmd_t   cmd
);
  import iht_pkg::*;

  typedef enum logic [14:0] {
    S_IDLE    = 15'b000000000000001,
    S_DECODE  = 15'b000000000000010,
    S_MUL1    = 15'b000000000000100,
    S_MUL2    = 15'b000000000001000,
    S_LDYAW   = 15'b000000000010000,
    S_AINIT   = 15'b000000000100000,
    S_NORM    = 15'b000000001000000,
    S_CORDIC  = 15'b000000010000000,
    S_ROUND   = 15'b000000100000000,
    S_PUSH    = 15'b000001000000000,
    S_RD      = 15'b000010000000000,
    S_ACC     = 15'b000100000000000,
    S_DIVINIT = 15'b001000000000000,
    S_DIV     = 15'b010000000000000,
    S_DONE    = 15'b100000000000000
  } state_t;

  state_t state_r, state_nxt;

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd.op    = DP_NOP;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op    = DP_LATCH;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        if (!st.cmd) begin
          priority if (st.kind == KIND_ROT || st.kind == KIND_GEO_ROT) begin
            state_nxt = S_MUL1;
          end else if (st.kind == KIND_RAW_MAG || st.kind == KIND_ACCEL ||
                       st.kind == KIND_GYRO || st.kind == KIND_CAL_MAG) begin
            cmd.op    = DP_STORE;
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_DONE;
          end
        end else begin
          priority if (st.mode == MODE_MAG) begin
            cmd.op    = DP_LDMAG;
            state_nxt = S_AINIT;
          end else if (st.mode == MODE_YAW) begin
            cmd.op    = DP_LDH;
            state_nxt = S_PUSH;
          end else begin
            state_nxt = S_DONE;
          end
        end
      end
      S_MUL1: begin
        cmd.op    = DP_MUL1;
        state_nxt = S_MUL2;
      end
      S_MUL2: begin
        cmd.op    = DP_MUL2;
        state_nxt = S_LDYAW;
      end
      S_LDYAW: begin
        cmd.op    = DP_LDYAW;
        state_nxt = S_AINIT;
      end
      S_AINIT: begin
        cmd.op    = DP_AINIT;
        state_nxt = st.xy_zero ? S_ROUND : S_NORM;
      end
      S_NORM: begin
        cmd.op = DP_NORM;
        if (st.norm_done) state_nxt = S_CORDIC;
      end
      S_CORDIC: begin
        cmd.op = DP_CORDIC;
        if (st.cordic_last) state_nxt = S_ROUND;
      end
      S_ROUND: begin
        cmd.op    = DP_ROUND;
        state_nxt = st.cmd ? S_PUSH : S_DONE;
      end
      S_PUSH: begin
        cmd.op    = DP_PUSH;
        state_nxt = S_RD;
      end
      S_RD: begin
        cmd.op    = DP_RD;
        state_nxt = S_ACC;
      end
      S_ACC: begin
        cmd.op    = DP_ACC;
        state_nxt = st.sweep_last ? S_DIVINIT : S_RD;
      end
      S_DIVINIT: begin
        cmd.op    = DP_DIVINIT;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        cmd.op = DP_DIV;
        if (st.div_last) state_nxt = S_DONE;
      end
      S_DONE: begin
        if (st.out_free) begin
          cmd.op    = DP_OUTLD;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  a_onehot: assert property (@(posedge clk) disable iff (!rst_n) $onehot(state_r))
    else $error("state register not one-hot");
  a_done_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && !st.out_free) |=> state_r == S_DONE)
    else $error("result dropped while output busy");
  a_idle_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && in_valid) |=> state_r == S_DECODE)
    else $error("accepted word not decoded");

endmodule

`default_nettype wire

[src/iht_dp.sv]
// datapath: sensor state, cordic atan2, heading ring, mean divider, output word
// depends on iht_pkg
`default_nettype none

module iht_dp #(
  parameter int DEPTH = iht_pkg::HISTORY_DEPTH_DEF
) (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  cfg_we,
  input  wire  [2:0]           cfg_addr,
  input  wire  [15:0]          cfg_wdata,
  input  wire                  in_cmd,
  input  wire  [2:0]           in_sensor_kind,
  input  wire  [1:0]           in_accuracy,
  input  wire  signed [15:0]   in_quat_i,
  input  wire  signed [15:0]   in_quat_j,
  input  wire  signed [15:0]   in_quat_k,
  input  wire  signed [15:0]   in_quat_real,
  input  wire  signed [15:0]   in_mag_x,
  input  wire  signed [15:0]   in_mag_y,
  input  wire                  out_stall,
  input  iht_pkg::iht_cmd_t    cmd,
  output iht_pkg::iht_status_t st,
  output logic                 out_valid,
  output logic signed [14:0]   out_heading_avg,
  output logic                 out_heading_valid,
  output logic                 out_fully_calibrated
);
  import iht_pkg::*;

  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int SUM_W = ANG_W + CNT_W;
  localparam int BIT_W = $clog2(SUM_W);
  localparam logic signed [XY_W-1:0] NORM_LIM = XY_W'(1) <<< NORM_SHIFT;
  localparam logic signed [Z_W-1:0]  Z_HALF   = Z_W'(180 * 65536);
  localparam logic signed [Z_W-1:0]  Z_HT     = Z_W'(HALF_TURN);

  // configuration
  logic [1:0]         mode_r;
  logic signed [14:0] yoff_r;
  logic signed [15:0] xmin_r, xmax_r, ymin_r, ymax_r;

  // sensor state
  logic signed [15:0] yaw_r, lmx_r, lmy_r;
  logic [1:0]         acc_a_r, acc_g_r, acc_m_r;

  // latched input word
  logic               c_r;
  logic [2:0]         kind_r;
  logic [1:0]         acc_r;
  logic signed [15:0] qi_r, qj_r, qk_r, qr_r, mx_r, my_r;

  // arithmetic
  logic signed [31:0]      pa_r, pb_r, pc_r, pd_r;
  logic signed [XY_W-1:0]  x_r, y_r;
  logic signed [Z_W-1:0]   z_r;
  logic [4:0]              s_r;
  logic signed [15:0]      h_r;

  // ring and mean
  logic signed [15:0]  mem [DEPTH];
  logic signed [15:0]  q_r;
  logic [IDX_W-1:0]    widx_r;
  logic                filled_r;
  logic [CNT_W-1:0]    count_r, rd_idx_r;
  logic signed [SUM_W-1:0] sum_r;
  logic [SUM_W-1:0]    dvd_r;
  logic [CNT_W-1:0]    rem_r;
  logic [BIT_W-1:0]    bit_r;
  logic                neg_r;

  logic                out_valid_r;
  logic signed [14:0]  out_avg_r;
  logic                out_hv_r, out_fc_r;

  // combinational helpers
  logic signed [XY_W-1:0] abs_y, xs, ys, ld_sy, ld_cx, ld_dx, ld_dy;
  logic signed [22:0]     atan_v;
  logic signed [Z_W-1:0]  zr;
  logic signed [15:0]     rnd;
  logic signed [16:0]     dif, wrapped;
  logic [IDX_W-1:0]       widx_nxt;
  logic                   filled_nxt;
  logic [CNT_W:0]         trial;
  logic                   ge;
  logic [SUM_W-1:0]       abs_sum;
  logic                   hd_ok;
  logic [14:0]            qv;

  assign abs_y  = y_r[XY_W-1] ? -y_r : y_r;
  assign xs     = x_r >>> s_r;
  assign ys     = y_r >>> s_r;
  assign atan_v = atan_lut(s_r);
  assign ld_sy  = (XY_W'(pa_r) + XY_W'(pb_r)) <<< 1;
  assign ld_cx  = (XY_W'(1) <<< 28) - ((XY_W'(pc_r) + XY_W'(pd_r)) <<< 1);
  assign ld_dx  = (XY_W'(lmx_r) <<< 1) - (XY_W'(xmin_r) + XY_W'(xmax_r));
  assign ld_dy  = (XY_W'(lmy_r) <<< 1) - (XY_W'(ymin_r) + XY_W'(ymax_r));

  always_comb begin
    zr = (z_r + Z_W'(512)) >>> 10;
    priority if (zr > Z_HT) rnd = 16'(HALF_TURN);
    else if (zr < -Z_HT)    rnd = -16'(HALF_TURN);
    else                    rnd = zr[15:0];
  end

  always_comb begin
    dif = 17'(h_r) - 17'(yoff_r);
    priority if (dif > 17'(HALF_TURN)) wrapped = dif - 17'(FULL_TURN);
    else if (dif < -17'(HALF_TURN))    wrapped = dif + 17'(FULL_TURN);
    else                               wrapped = dif;
  end

  always_comb begin
    if (widx_r == IDX_W'(DEPTH - 1)) begin
      widx_nxt   = '0;
      filled_nxt = 1'b1;
    end else begin
      widx_nxt   = widx_r + 1'b1;
      filled_nxt = filled_r;
    end
  end

  assign trial   = {rem_r, dvd_r[SUM_W-1]};
  assign ge      = trial >= {1'b0, count_r};
  assign abs_sum = sum_r[SUM_W-1] ? SUM_W'(-sum_r) : SUM_W'(sum_r);
  assign hd_ok   = c_r && (mode_r == MODE_MAG || mode_r == MODE_YAW);
  assign qv      = dvd_r[14:0];

  assign st.cmd         = c_r;
  assign st.kind        = kind_r;
  assign st.mode        = mode_r;
  assign st.xy_zero     = (x_r == '0) && (y_r == '0);
  assign st.norm_done   = (x_r >= NORM_LIM) || (abs_y >= NORM_LIM);
  assign st.cordic_last = (s_r == 5'(CORDIC_STEPS - 1));
  assign st.sweep_last  = (rd_idx_r == count_r - 1'b1);
  assign st.div_last    = (bit_r == BIT_W'(SUM_W - 1));
  assign st.out_free    = !out_valid_r || !out_stall;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_YAW;
      yoff_r <= '0;
      xmin_r <= '0;
      xmax_r <= '0;
      ymin_r <= '0;
      ymax_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_HEADING_MODE: mode_r <= cfg_wdata[1:0];
        REG_YAW_OFFSET:   yoff_r <= cfg_wdata[14:0];
        REG_MAG_X_MIN:    xmin_r <= cfg_wdata;
        REG_MAG_X_MAX:    xmax_r <= cfg_wdata;
        REG_MAG_Y_MIN:    ymin_r <= cfg_wdata;
        REG_MAG_Y_MAX:    ymax_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // sensor state and ring pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      yaw_r    <= '0;
      lmx_r    <= '0;
      lmy_r    <= '0;
      acc_a_r  <= '0;
      acc_g_r  <= '0;
      acc_m_r  <= '0;
      widx_r   <= '0;
      filled_r <= 1'b0;
    end else begin
      if (cmd.op == DP_STORE) begin
        unique case (kind_r)
          KIND_RAW_MAG: begin
            lmx_r <= mx_r;
            lmy_r <= my_r;
          end
          KIND_ACCEL:   acc_a_r <= acc_r;
          KIND_GYRO:    acc_g_r <= acc_r;
          KIND_CAL_MAG: acc_m_r <= acc_r;
          default: ;
        endcase
      end
      if (cmd.op == DP_ROUND && !c_r) yaw_r <= rnd;
      if (cmd.op == DP_PUSH) begin
        widx_r   <= widx_nxt;
        filled_r <= filled_nxt;
      end
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    unique case (cmd.op)
      DP_LATCH: begin
        c_r    <= in_cmd;
        kind_r <= in_sensor_kind;
        acc_r  <= in_accuracy;
        qi_r   <= in_quat_i;
        qj_r   <= in_quat_j;
        qk_r   <= in_quat_k;
        qr_r   <= in_quat_real;
        mx_r   <= in_mag_x;
        my_r   <= in_mag_y;
      end
      DP_MUL1: begin
        pa_r <= qr_r * qk_r;
        pb_r <= qi_r * qj_r;
      end
      DP_MUL2: begin
        pc_r <= qj_r * qj_r;
        pd_r <= qk_r * qk_r;
      end
      DP_LDYAW: begin
        x_r <= ld_cx;
        y_r <= ld_sy;
      end
      DP_LDMAG: begin
        x_r <= ld_dx;
        y_r <= ld_dy;
      end
      DP_AINIT: begin
        s_r <= '0;
        if (x_r[XY_W-1]) begin
          z_r <= y_r[XY_W-1] ? -Z_HALF : Z_HALF;
          x_r <= -x_r;
          y_r <= -y_r;
        end else begin
          z_r <= '0;
        end
      end
      DP_NORM: begin
        if (!st.norm_done) begin
          x_r <= x_r <<< 1;
          y_r <= y_r <<< 1;
        end
      end
      DP_CORDIC: begin
        s_r <= s_r + 1'b1;
        if (y_r > 0) begin
          x_r <= x_r + ys;
          y_r <= y_r - xs;
          z_r <= z_r + Z_W'(atan_v);
        end else begin
          x_r <= x_r - ys;
          y_r <= y_r + xs;
          z_r <= z_r - Z_W'(atan_v);
        end
      end
      DP_ROUND: h_r <= rnd;
      DP_LDH:   h_r <= yaw_r;
      DP_PUSH: begin
        count_r  <= filled_nxt ? CNT_W'(DEPTH) : CNT_W'(widx_nxt);
        rd_idx_r <= '0;
        sum_r    <= '0;
      end
      DP_ACC: begin
        sum_r    <= sum_r + SUM_W'(q_r);
        rd_idx_r <= rd_idx_r + 1'b1;
      end
      DP_DIVINIT: begin
        neg_r <= sum_r[SUM_W-1];
        dvd_r <= abs_sum + SUM_W'(count_r >> 1);
        rem_r <= '0;
        bit_r <= '0;
      end
      DP_DIV: begin
        rem_r <= ge ? CNT_W'(trial - {1'b0, count_r}) : trial[CNT_W-1:0];
        dvd_r <= {dvd_r[SUM_W-2:0], ge};
        bit_r <= bit_r + 1'b1;
      end
      default: ;
    endcase
  end

  // heading ring
  always_ff @(posedge clk) begin
    if (cmd.op == DP_PUSH) mem[widx_r] <= wrapped[15:0];
    if (cmd.op == DP_RD)   q_r <= mem[rd_idx_r[IDX_W-1:0]];
  end

  // output word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.op == DP_OUTLD) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == DP_OUTLD) begin
      out_hv_r  <= hd_ok;
      out_avg_r <= hd_ok ? (neg_r ? -qv : qv) : '0;
      out_fc_r  <= (acc_a_r == ACC_HIGH) && (acc_g_r == ACC_HIGH) && (acc_m_r == ACC_HIGH);
    end
  end

  assign out_valid            = out_valid_r;
  assign out_heading_avg      = out_avg_r;
  assign out_heading_valid    = out_hv_r;
  assign out_fully_calibrated = out_fc_r;

  a_widx_range: assert property (@(posedge clk) disable iff (!rst_n)
    widx_r <= IDX_W'(DEPTH - 1))
    else $error("ring write pointer out of range");
  a_outld: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.op == DP_OUTLD |=> out_valid_r)
    else $error("output word not presented");
  a_rem: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.op == DP_DIV |-> rem_r < count_r)
    else $error("divider remainder not below divisor");

endmodule

`default_nettype wire

[src/imu_heading_tracker.sv]
// heading tracker top: one word in, one word out, next word taken when idle
// sensor updates are stored at decode; yaw events and magnetometer-mode requests
// run a normalising shift then cordic iterations in one shared unit;
// requests add a read-and-add ring sweep and a 1-bit-a-cycle divider
// synchronous active-low reset clears state, ring pointers and configuration
`default_nettype none

module imu_heading_tracker #(
  parameter int HISTORY_DEPTH = iht_pkg::HISTORY_DEPTH_DEF
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 cfg_valid,
  output logic                cfg_ready,
  input  wire  [2:0]          cfg_addr,
  input  wire  [15:0]         cfg_wdata,
  input  wire                 in_valid,
  output logic                in_stall,
  input  wire                 in_cmd,
  input  wire  [2:0]          in_sensor_kind,
  input  wire  [1:0]          in_accuracy,
  input  wire  signed [15:0]  in_quat_i,
  input  wire  signed [15:0]  in_quat_j,
  input  wire  signed [15:0]  in_quat_k,
  input  wire  signed [15:0]  in_quat_real,
  input  wire  signed [15:0]  in_mag_x,
  input  wire  signed [15:0]  in_mag_y,
  output logic                out_valid,
  input  wire                 out_stall,
  output logic signed [14:0]  out_heading_avg,
  output logic                out_heading_valid,
  output logic                out_fully_calibrated
);
  import iht_pkg::*;

  iht_cmd_t    cmd;
  iht_status_t st;

  assign cfg_ready = 1'b1;

  iht_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .st       (st),
    .cmd      (cmd)
  );

  iht_dp #(
    .DEPTH (HISTORY_DEPTH)
  ) u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_we               (cfg_valid & cfg_ready),
    .cfg_addr             (cfg_addr),
    .cfg_wdata            (cfg_wdata),
    .in_cmd               (in_cmd),
    .in_sensor_kind       (in_sensor_kind),
    .in_accuracy          (in_accuracy),
    .in_quat_i            (in_quat_i),
    .in_quat_j            (in_quat_j),
    .in_quat_k            (in_quat_k),
    .in_quat_real         (in_quat_real),
    .in_mag_x             (in_mag_x),
    .in_mag_y             (in_mag_y),
    .out_stall            (out_stall),
    .cmd                  (cmd),
    .st                   (st),
    .out_valid            (out_valid),
    .out_heading_avg      (out_heading_avg),
    .out_heading_valid    (out_heading_valid),
    .out_fully_calibrated (out_fully_calibrated)
  );

endmodule

`default_nettype wire
